// ----- rtl/hrle_pkg.sv -----
// ----------------------------------------------------------------------------
// hrle_pkg
// Shared types and constants for the hdr scanline run-length decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hrle_pkg;

   // result action codes
   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_STORE = 2'd1;
   localparam logic [1:0] ACT_FILL  = 2'd2;
   localparam logic [1:0] ACT_COPY  = 2'd3;

   localparam logic [15:0] WIDTH_RESET   = 16'd8;
   localparam logic [15:0] MIN_RLE_WIDTH = 16'd8;
   localparam logic [15:0] MAX_RLE_WIDTH = 16'h7fff;
   localparam logic [23:0] REPEAT_MARK   = 24'h010101;

   // classified input byte as it travels through the queue
   typedef struct packed {
      logic [7:0] data;
      logic       is_two;
      logic       is_run;
      logic       is_zero;
   } item_type;

endpackage

`default_nettype wire

// ----- rtl/hrle_front.sv -----
// ----------------------------------------------------------------------------
// hrle_front
// Classifies each incoming byte: header mark, run code or zero code.
// ----------------------------------------------------------------------------
`default_nettype none

module hrle_front (
   input  wire logic [7:0]       data_byte,
   output hrle_pkg::item_type    item
);

   // byte classification
   always_comb begin
      item.data    = data_byte;
      item.is_two  = (data_byte == 8'd2);
      item.is_run  = (data_byte > 8'd128);
      item.is_zero = (data_byte == 8'd0);
   end

endmodule

`default_nettype wire

// ----- rtl/hrle_queue.sv -----
// ----------------------------------------------------------------------------
// hrle_queue
// Two-entry queue between the classifier and the decode engine.
// ----------------------------------------------------------------------------
`default_nettype none

module hrle_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire hrle_pkg::item_type push_item,
   output logic                    full,
   input  wire logic               pop,
   output logic                    not_empty,
   output hrle_pkg::item_type      pop_item
);

   hrle_pkg::item_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_item  = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/hrle_back.sv -----
// ----------------------------------------------------------------------------
// hrle_back
// Decode engine: scanline state machine and registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hrle_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [15:0]        csr_wr_data,
   input  wire logic               item_avail,
   input  wire hrle_pkg::item_type item,
   output logic                    item_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_action,
   output logic [15:0]             rsp_column,
   output logic [1:0]              rsp_channel,
   output logic [15:0]             rsp_count,
   output logic [7:0]              rsp_fill_value,
   output logic [7:0]              rsp_red,
   output logic [7:0]              rsp_green,
   output logic [7:0]              rsp_blue,
   output logic [7:0]              rsp_exponent,
   output logic                    rsp_line_end,
   output logic                    rsp_overrun
);

   typedef enum logic [2:0] {
      PH_START, PH_HDR_G, PH_HDR_B, PH_HDR_E, PH_CODE, PH_RUN, PH_LIT, PH_FLAT
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] width_ff;
   logic [7:0]  hdr_g_ff, hdr_g_in;
   logic [7:0]  hdr_b_ff, hdr_b_in;
   logic [1:0]  chan_ff, chan_in;
   logic [15:0] col_ff, col_in;
   logic [7:0]  pend_ff, pend_in;
   logic [23:0] pix_ff, pix_in;
   logic [1:0]  bpos_ff, bpos_in;
   logic [31:0] prev_ff, prev_in;
   logic [4:0]  shift_ff, shift_in;

   logic        out_valid_ff;
   logic [1:0]  act_ff, act_in;
   logic [15:0] ocol_ff, ocol_in;
   logic [1:0]  och_ff, och_in;
   logic [15:0] ocnt_ff, ocnt_in;
   logic [7:0]  fill_ff, fill_in;
   logic [31:0] px_ff, px_in;
   logic        end_ff, end_in;
   logic        ovr_ff, ovr_in;
   logic        res_in;

   logic [15:0] w;
   logic [15:0] rem;
   logic [15:0] cnt;
   logic [15:0] newcol;
   logic [31:0] total;
   logic [7:0]  pend_dec;
   logic [31:0] px_new;

   assign item_pop  = item_avail && (!out_valid_ff || !rsp_stall);
   assign w         = (width_ff == 16'd0) ? 16'd1 : width_ff;
   assign rem       = (col_ff < w) ? (w - col_ff) : 16'd0;
   assign total     = {24'd0, item.data} << shift_ff;
   assign pend_dec  = pend_ff - 8'd1;
   assign px_new    = {item.data, pix_ff};

   // next state and result for one byte
   always_comb begin
      phase_in = phase_ff;
      hdr_g_in = hdr_g_ff;
      hdr_b_in = hdr_b_ff;
      chan_in  = chan_ff;
      col_in   = col_ff;
      pend_in  = pend_ff;
      pix_in   = pix_ff;
      bpos_in  = bpos_ff;
      prev_in  = prev_ff;
      shift_in = shift_ff;
      res_in   = 1'b0;
      act_in   = hrle_pkg::ACT_NONE;
      ocol_in  = 16'd0;
      och_in   = 2'd0;
      ocnt_in  = 16'd0;
      fill_in  = 8'd0;
      px_in    = 32'd0;
      end_in   = 1'b0;
      ovr_in   = 1'b0;
      cnt      = 16'd0;
      newcol   = col_ff;
      unique case (phase_ff)
         PH_START: begin
            chan_in  = 2'd0;
            col_in   = 16'd0;
            pend_in  = 8'd0;
            shift_in = 5'd0;
            if (w >= hrle_pkg::MIN_RLE_WIDTH && w <= hrle_pkg::MAX_RLE_WIDTH
                && item.is_two) begin
               phase_in = PH_HDR_G;
            end else begin
               pix_in   = {16'd0, item.data};
               bpos_in  = 2'd1;
               phase_in = PH_FLAT;
            end
         end
         PH_HDR_G: begin
            hdr_g_in = item.data;
            phase_in = PH_HDR_B;
         end
         PH_HDR_B: begin
            hdr_b_in = item.data;
            phase_in = PH_HDR_E;
         end
         PH_HDR_E: begin
            if (hdr_g_ff != 8'd2 || hdr_b_ff[7]) begin
               // not a coded line: header bytes form the first flat pixel
               px_in    = {item.data, hdr_b_ff, hdr_g_ff, 8'd2};
               prev_in  = px_in;
               col_in   = 16'd1;
               shift_in = 5'd0;
               bpos_in  = 2'd0;
               phase_in = PH_FLAT;
               res_in   = 1'b1;
               act_in   = hrle_pkg::ACT_STORE;
               ocnt_in  = 16'd1;
               if (w == 16'd1) begin
                  end_in   = 1'b1;
                  phase_in = PH_START;
               end
            end else begin
               chan_in  = 2'd0;
               col_in   = 16'd0;
               phase_in = PH_CODE;
            end
         end
         PH_CODE: begin
            if (item.is_run) begin
               pend_in  = {1'b0, item.data[6:0]};
               phase_in = PH_RUN;
            end else if (!item.is_zero) begin
               pend_in  = item.data;
               phase_in = PH_LIT;
            end
         end
         PH_RUN: begin
            cnt      = ({8'd0, pend_ff} < rem) ? {8'd0, pend_ff} : rem;
            newcol   = col_ff + cnt;
            col_in   = newcol;
            pend_in  = 8'd0;
            phase_in = PH_CODE;
            res_in   = 1'b1;
            act_in   = hrle_pkg::ACT_FILL;
            ocol_in  = col_ff;
            och_in   = chan_ff;
            ocnt_in  = cnt;
            fill_in  = item.data;
            ovr_in   = ({8'd0, pend_ff} > rem);
            if (newcol >= w) begin
               if (chan_ff == 2'd3) begin
                  phase_in = PH_START;
                  end_in   = 1'b1;
               end else begin
                  chan_in = chan_ff + 2'd1;
                  col_in  = 16'd0;
               end
            end
         end
         PH_LIT: begin
            res_in  = 1'b1;
            pend_in = pend_dec;
            if (col_ff < w) begin
               newcol  = col_ff + 16'd1;
               act_in  = hrle_pkg::ACT_FILL;
               ocol_in = col_ff;
               och_in  = chan_ff;
               ocnt_in = 16'd1;
               fill_in = item.data;
            end else begin
               ovr_in = 1'b1;
            end
            col_in = newcol;
            if (pend_dec == 8'd0) begin
               phase_in = PH_CODE;
               if (newcol >= w) begin
                  if (chan_ff == 2'd3) begin
                     phase_in = PH_START;
                     end_in   = 1'b1;
                  end else begin
                     chan_in = chan_ff + 2'd1;
                     col_in  = 16'd0;
                  end
               end
            end
         end
         PH_FLAT: begin
            if (bpos_ff != 2'd3) begin
               // gather the first three bytes of a pixel
               unique case (bpos_ff)
                  2'd0:    pix_in = {16'd0, item.data};
                  2'd1:    pix_in = {pix_ff[23:16], item.data, pix_ff[7:0]};
                  default: pix_in = {item.data, pix_ff[15:0]};
               endcase
               bpos_in = bpos_ff + 2'd1;
            end else begin
               bpos_in = 2'd0;
               res_in  = 1'b1;
               ocol_in = col_ff;
               if (pix_ff == hrle_pkg::REPEAT_MARK) begin
                  // repeat of the previous pixel
                  cnt      = (total < {16'd0, rem}) ? total[15:0] : rem;
                  ovr_in   = (total > {16'd0, rem});
                  newcol   = col_ff + cnt;
                  col_in   = newcol;
                  shift_in = (shift_ff >= 5'd16) ? 5'd24 : shift_ff + 5'd8;
                  act_in   = hrle_pkg::ACT_COPY;
                  ocnt_in  = cnt;
               end else begin
                  newcol   = col_ff + 16'd1;
                  col_in   = newcol;
                  prev_in  = px_new;
                  shift_in = 5'd0;
                  act_in   = hrle_pkg::ACT_STORE;
                  ocnt_in  = 16'd1;
                  px_in    = px_new;
               end
               if (newcol >= w) begin
                  end_in   = 1'b1;
                  phase_in = PH_START;
               end
            end
         end
         default: phase_in = PH_START;
      endcase
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         width_ff <= hrle_pkg::WIDTH_RESET;
         hdr_g_ff <= 8'd0;
         hdr_b_ff <= 8'd0;
         chan_ff  <= 2'd0;
         col_ff   <= 16'd0;
         pend_ff  <= 8'd0;
         pix_ff   <= 24'd0;
         bpos_ff  <= 2'd0;
         prev_ff  <= 32'd0;
         shift_ff <= 5'd0;
      end else begin
         if (csr_wr_en) begin
            width_ff <= csr_wr_data;
         end
         if (item_pop) begin
            phase_ff <= phase_in;
            hdr_g_ff <= hdr_g_in;
            hdr_b_ff <= hdr_b_in;
            chan_ff  <= chan_in;
            col_ff   <= col_in;
            pend_ff  <= pend_in;
            pix_ff   <= pix_in;
            bpos_ff  <= bpos_in;
            prev_ff  <= prev_in;
            shift_ff <= shift_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (item_pop) begin
         out_valid_ff <= res_in;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop && res_in) begin
         act_ff  <= act_in;
         ocol_ff <= ocol_in;
         och_ff  <= och_in;
         ocnt_ff <= ocnt_in;
         fill_ff <= fill_in;
         px_ff   <= (act_in == hrle_pkg::ACT_STORE) ? px_in : 32'd0;
         end_ff  <= end_in;
         ovr_ff  <= ovr_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_action     = act_ff;
   assign rsp_column     = ocol_ff;
   assign rsp_channel    = och_ff;
   assign rsp_count      = ocnt_ff;
   assign rsp_fill_value = fill_ff;
   assign rsp_red        = px_ff[7:0];
   assign rsp_green      = px_ff[15:8];
   assign rsp_blue       = px_ff[23:16];
   assign rsp_exponent   = px_ff[31:24];
   assign rsp_line_end   = end_ff;
   assign rsp_overrun    = ovr_ff;

endmodule

`default_nettype wire

// ----- rtl/hdr_rle_scanline_decoder.sv -----
// Order: an accepted byte is written to the queue at the accepting edge, and the
// result register is written when the engine pops it; a result stall can hold that off.
// Throughput: one byte per cycle; the decode engine retires one byte each cycle the
// result register is free or being taken, and the two-entry queue absorbs stalls.
// Reset: synchronous, active high; clears the decoder state, the queue and the
// result valid, and sets line_width to 8.
// ----------------------------------------------------------------------------
// hdr_rle_scanline_decoder
// Top level: byte classifier, transaction queue and decode engine.
// ----------------------------------------------------------------------------
`default_nettype none

module hdr_rle_scanline_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_action,
   output logic [15:0]      rsp_column,
   output logic [1:0]       rsp_channel,
   output logic [15:0]      rsp_count,
   output logic [7:0]       rsp_fill_value,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic [7:0]       rsp_exponent,
   output logic             rsp_line_end,
   output logic             rsp_overrun
);

   hrle_pkg::item_type in_item;
   hrle_pkg::item_type q_item;
   logic               q_full;
   logic               q_avail;
   logic               q_pop;

   assign req_stall = q_full;

   // classify incoming bytes
   hrle_front u_front (
      .data_byte (req_data_byte),
      .item      (in_item)
   );

   // queue between classifier and engine
   hrle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !q_full),
      .push_item (in_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_avail),
      .pop_item  (q_item)
   );

   // decode engine
   hrle_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .item_avail     (q_avail),
      .item           (q_item),
      .item_pop       (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_action     (rsp_action),
      .rsp_column     (rsp_column),
      .rsp_channel    (rsp_channel),
      .rsp_count      (rsp_count),
      .rsp_fill_value (rsp_fill_value),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_exponent   (rsp_exponent),
      .rsp_line_end   (rsp_line_end),
      .rsp_overrun    (rsp_overrun)
   );

endmodule

`default_nettype wire
